// ===== rtl/rsd_pkg.sv =====
// Shared types and constants for the radial stick dead zone pipeline.
`default_nettype none
package rsd_pkg;

   localparam logic [14:0] FullScale  = 15'd32767;
   localparam int          SqrtCells  = 24;
   localparam int          DivCells   = 15;
   localparam int          Stages     = 44;

   // One step of the digit-by-digit square root: radicand bits still to go,
   // partial remainder and partial root.
   typedef struct packed {
      logic [47:0] n;
      logic [25:0] rem;
      logic [23:0] root;
   } sqrt_type;

   // One step of the long division: partial remainder, numerator bits still
   // to go, quotient so far and the divisor.
   typedef struct packed {
      logic [38:0] p;
      logic [14:0] lo;
      logic [14:0] q;
      logic [38:0] den;
   } div_type;

   // Data that rides along beside the arithmetic.
   typedef struct packed {
      logic        dead;
      logic        neg_x;
      logic        neg_y;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [14:0] r;
   } side_type;

endpackage
`default_nettype wire

// ===== rtl/rsd_sqrt_cell.sv =====
// One registered step of the pipelined square root, two radicand bits per cell.
`default_nettype none
module rsd_sqrt_cell (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire rsd_pkg::sqrt_type d_in,
   output rsd_pkg::sqrt_type      d_out
);

   logic [27:0]       sh;
   logic [27:0]       trial;
   logic [27:0]       diff;
   rsd_pkg::sqrt_type st_in;
   rsd_pkg::sqrt_type st_ff;

   always_comb begin
      sh       = {d_in.rem, d_in.n[47:46]};
      trial    = {2'b00, d_in.root, 2'b01};
      diff     = sh - trial;
      st_in.n  = {d_in.n[45:0], 2'b00};
      if (sh >= trial) begin
         st_in.rem  = diff[25:0];
         st_in.root = {d_in.root[22:0], 1'b1};
      end else begin
         st_in.rem  = sh[25:0];
         st_in.root = {d_in.root[22:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign d_out = st_ff;

endmodule
`default_nettype wire

// ===== rtl/rsd_div_cell.sv =====
// One registered step of the pipelined restoring divider, one quotient bit per cell.
`default_nettype none
module rsd_div_cell (
   input  wire logic             clock,
   input  wire logic             adv,
   input  wire rsd_pkg::div_type d_in,
   output rsd_pkg::div_type      d_out
);

   logic [39:0]      t;
   logic [39:0]      dext;
   logic [39:0]      diff;
   rsd_pkg::div_type st_in;
   rsd_pkg::div_type st_ff;

   always_comb begin
      t         = {d_in.p, d_in.lo[14]};
      dext      = {1'b0, d_in.den};
      diff      = t - dext;
      st_in.lo  = {d_in.lo[13:0], 1'b0};
      st_in.den = d_in.den;
      if (t >= dext) begin
         st_in.p = diff[38:0];
         st_in.q = {d_in.q[13:0], 1'b1};
      end else begin
         st_in.p = t[38:0];
         st_in.q = {d_in.q[13:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign d_out = st_ff;

endmodule
`default_nettype wire

// ===== rtl/radial_stick_deadzone.sv =====
// Radial dead zone for an analog stick: top level with pipeline, skid and output register.
//
// Requests (req_stick_x, req_stick_y) enter on req_valid when req_stall is low.
// Each request gives one response (rsp_out_x, rsp_out_y) on rsp_valid, taken
// when rsp_stall is low. The user must write the radius through csr_wen/csr_wdata
// only while no request is in flight; the block does not enforce it. It resets to 0.
// One request is accepted every cycle while req_stall is low: squares, compare,
// a 24-cell square root row (two radicand bits per cell), scaling multipliers
// and two 15-cell divider rows (one quotient bit per cell) each advance once
// per cycle while the pipeline is not held.
// A stalled response holds in the output register; the next finished result
// drops into a one-entry skid stage. Only while the skid is full does the
// pipeline hold and req_stall rise.
// Reset empties the pipeline, the skid and the output register and clears
// the radius; no clearing pass is needed.
`default_nettype none
module radial_stick_deadzone (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_stick_x,
   input  wire logic [15:0] req_stick_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_out_x,
   output logic [15:0]      rsp_out_y,
   input  wire logic        csr_wen,
   input  wire logic [14:0] csr_wdata
);

   logic [14:0]                     radius_ff;
   logic                            adv;
   logic                            take;
   logic [rsd_pkg::Stages-1:0]      vld_ff;
   logic [rsd_pkg::Stages-1:0]      vld_in;
   rsd_pkg::side_type               side_ff [rsd_pkg::Stages];
   rsd_pkg::side_type               side0_in;
   rsd_pkg::side_type               side1_in;

   logic [31:0] xx_ff, yy_ff;
   logic [29:0] rr_ff;
   logic [31:0] m2_ff;
   logic [31:0] m2_in;

   logic [23:0] mag_ff;
   logic [22:0] d_ff;
   logic [14:0] rs_ff;
   logic [22:0] clip;
   logic [22:0] rsh;
   logic [38:0] den_ff;
   logic [38:0] px_ff, py_ff;
   logic [53:0] nx_ff, ny_ff;
   logic [38:0] denc_ff;

   rsd_pkg::sqrt_type sq_link [rsd_pkg::SqrtCells+1];
   rsd_pkg::div_type  dx_link [rsd_pkg::DivCells+1];
   rsd_pkg::div_type  dy_link [rsd_pkg::DivCells+1];

   logic [15:0] fin_x, fin_y;
   logic        new_v;
   logic        out_take;
   logic        skid_full_ff;
   logic [15:0] skid_x_ff, skid_y_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_x_ff, rsp_y_ff;

   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign take      = req_valid && adv;
   assign vld_in    = {vld_ff[rsd_pkg::Stages-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_wen) begin
         radius_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: magnitudes of the axes and their squares.
   always_comb begin
      side0_in.dead  = 1'b0;
      side0_in.neg_x = req_stick_x[15];
      side0_in.neg_y = req_stick_y[15];
      side0_in.ax    = req_stick_x[15] ? (16'd0 - req_stick_x) : req_stick_x;
      side0_in.ay    = req_stick_y[15] ? (16'd0 - req_stick_y) : req_stick_y;
      side0_in.r     = radius_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff      <= side0_in.ax * side0_in.ax;
         yy_ff      <= side0_in.ay * side0_in.ay;
         rr_ff      <= radius_ff * radius_ff;
      end
   end

   // Stage 1: squared magnitude and dead zone test.
   assign m2_in = xx_ff + yy_ff;

   always_comb begin
      side1_in      = side_ff[0];
      side1_in.dead = (m2_in <= {2'b00, rr_ff}) ||
                      (side_ff[0].r == rsd_pkg::FullScale);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_ff <= m2_in;
      end
   end

   // Side data advances one stage per cycle beside the arithmetic while the pipeline is not held.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side0_in;
         side_ff[1] <= side1_in;
         for (int k = 2; k < rsd_pkg::Stages; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Square root of m2 * 2^16, 8 fraction bits.
   assign sq_link[0].n    = {m2_ff, 16'd0};
   assign sq_link[0].rem  = '0;
   assign sq_link[0].root = '0;

   for (genvar j = 0; j < rsd_pkg::SqrtCells; j++) begin : g_sqrt
      rsd_sqrt_cell u_cell (
         .clock (clock),
         .adv   (adv),
         .d_in  (sq_link[j]),
         .d_out (sq_link[j+1])
      );
   end

   // Clip the magnitude and take off the radius.
   always_comb begin
      clip = (sq_link[rsd_pkg::SqrtCells].root > {1'b0, rsd_pkg::FullScale, 8'd0}) ?
             {rsd_pkg::FullScale, 8'd0} : sq_link[rsd_pkg::SqrtCells].root[22:0];
      rsh  = {side_ff[rsd_pkg::SqrtCells+1].r, 8'd0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= sq_link[rsd_pkg::SqrtCells].root;
         d_ff   <= (clip > rsh) ? (clip - rsh) : '0;
         rs_ff  <= rsd_pkg::FullScale - side_ff[rsd_pkg::SqrtCells+1].r;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff  <= mag_ff * rs_ff;
         px_ff   <= side_ff[rsd_pkg::SqrtCells+2].ax * d_ff;
         py_ff   <= side_ff[rsd_pkg::SqrtCells+2].ay * d_ff;
         denc_ff <= den_ff;
         nx_ff   <= {px_ff, 15'd0} - {15'd0, px_ff};
         ny_ff   <= {py_ff, 15'd0} - {15'd0, py_ff};
      end
   end

   // Quotient fits in 15 bits, so the top 39 numerator bits start below den.
   assign dx_link[0].p   = nx_ff[53:15];
   assign dx_link[0].lo  = nx_ff[14:0];
   assign dx_link[0].q   = '0;
   assign dx_link[0].den = denc_ff;
   assign dy_link[0].p   = ny_ff[53:15];
   assign dy_link[0].lo  = ny_ff[14:0];
   assign dy_link[0].q   = '0;
   assign dy_link[0].den = denc_ff;

   for (genvar k = 0; k < rsd_pkg::DivCells; k++) begin : g_div
      rsd_div_cell u_cell_x (
         .clock (clock),
         .adv   (adv),
         .d_in  (dx_link[k]),
         .d_out (dx_link[k+1])
      );
      rsd_div_cell u_cell_y (
         .clock (clock),
         .adv   (adv),
         .d_in  (dy_link[k]),
         .d_out (dy_link[k+1])
      );
   end

   // Apply sign and dead zone.
   always_comb begin
      if (side_ff[rsd_pkg::Stages-1].dead) begin
         fin_x = '0;
         fin_y = '0;
      end else begin
         fin_x = side_ff[rsd_pkg::Stages-1].neg_x ?
                 (16'd0 - {1'b0, dx_link[rsd_pkg::DivCells].q}) :
                 {1'b0, dx_link[rsd_pkg::DivCells].q};
         fin_y = side_ff[rsd_pkg::Stages-1].neg_y ?
                 (16'd0 - {1'b0, dy_link[rsd_pkg::DivCells].q}) :
                 {1'b0, dy_link[rsd_pkg::DivCells].q};
      end
   end

   assign new_v    = vld_ff[rsd_pkg::Stages-1] && adv;
   assign out_take = !rsp_valid_ff || !rsp_stall;

   // Output register with a one-entry skid behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_full_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_x_ff     <= skid_x_ff;
            rsp_y_ff     <= skid_y_ff;
            skid_full_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= new_v;
            rsp_x_ff     <= fin_x;
            rsp_y_ff     <= fin_y;
         end
      end else if (new_v) begin
         skid_x_ff    <= fin_x;
         skid_y_ff    <= fin_y;
         skid_full_ff <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid holds a request while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && rsp_stall |=> skid_full_ff)
      else $error("skid drained while the response was stalled");

   a_live_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] && !side_ff[1].dead |-> m2_ff != 32'd0)
      else $error("zero vector passed the dead zone test");

endmodule
`default_nettype wire
